// ----- sv/spf_pkg.sv -----
// Shared types and constants for the servo packet framer.
`default_nettype none

package spf_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] SHORT_LEN = 8'd2;
    localparam logic [7:0] HDR_EXTRA = 8'd3;

    // command kinds handed from front to back
    localparam logic [1:0] K_LONG  = 2'd0;
    localparam logic [1:0] K_SHORT = 2'd1;
    localparam logic [1:0] K_PAY   = 2'd2;

    // byte sequencer steps
    localparam logic [2:0] ST_SYNC0 = 3'd0;
    localparam logic [2:0] ST_SYNC1 = 3'd1;
    localparam logic [2:0] ST_ID    = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_INST  = 3'd4;
    localparam logic [2:0] ST_ADDR  = 3'd5;
    localparam logic [2:0] ST_DATA  = 3'd6;
    localparam logic [2:0] ST_CKS   = 3'd7;

    localparam int IN_TDATA_W = 40;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] id;
        logic [7:0] inst;
        logic [7:0] addr;
        logic [7:0] len;
        logic [7:0] data;
        logic [7:0] cks;
        logic       has_cks;
    } t_cmd;

endpackage

`default_nettype wire

// ----- sv/spf_front.sv -----
// Front end: accepts items, tracks packet position and checksum, builds commands.
`default_nettype none

module spf_front import spf_pkg::*; #(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_vld,
    output logic                       o_rdy,
    input  wire logic [IN_TDATA_W-1:0] i_data,
    output logic                       o_cmd_vld,
    output t_cmd                       o_cmd,
    input  wire logic                  i_cmd_rdy
);

    localparam int BL_W = $clog2(MAX_PAYLOAD + 1);

    logic [BL_W-1:0] r_bytes_left, n_bytes_left;
    logic [7:0]      r_sum, n_sum;

    logic [7:0] id, inst, addr, data;
    logic [6:0] plen;
    logic [7:0] nsat;
    logic [7:0] sum_first;
    logic [7:0] sum_pay;
    logic [7:0] len_long;
    logic       accept;
    t_cmd       cmd;

    assign id   = i_data[7:0];
    assign inst = i_data[15:8];
    assign addr = i_data[23:16];
    assign plen = i_data[30:24];
    assign data = i_data[38:31];

    assign nsat      = ({1'b0, plen} > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : {1'b0, plen};
    assign len_long  = nsat + HDR_EXTRA;
    assign sum_first = id + len_long + inst + addr + data;
    assign sum_pay   = r_sum + data;

    assign o_rdy     = i_cmd_rdy;
    assign o_cmd_vld = i_vld;
    assign accept    = i_vld && i_cmd_rdy;
    assign o_cmd     = cmd;

    always_comb begin
        cmd          = '0;
        cmd.id       = id;
        cmd.inst     = inst;
        cmd.addr     = addr;
        cmd.data     = data;
        n_bytes_left = r_bytes_left;
        n_sum        = r_sum;
        if (r_bytes_left != '0) begin
            cmd.kind     = K_PAY;
            n_bytes_left = r_bytes_left - BL_W'(1);
            cmd.has_cks  = (n_bytes_left == '0);
            cmd.cks      = ~sum_pay;
            n_sum        = cmd.has_cks ? 8'd0 : sum_pay;
        end else if (plen == 7'd0) begin
            cmd.kind    = K_SHORT;
            cmd.len     = SHORT_LEN;
            cmd.has_cks = 1'b1;
            cmd.cks     = ~(id + SHORT_LEN + inst);
            n_sum       = 8'd0;
        end else begin
            cmd.kind     = K_LONG;
            cmd.len      = len_long;
            n_bytes_left = BL_W'(nsat - 8'd1);
            cmd.has_cks  = (n_bytes_left == '0);
            cmd.cks      = ~sum_first;
            n_sum        = cmd.has_cks ? 8'd0 : sum_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_sum        <= 8'd0;
        end else if (accept) begin
            r_bytes_left <= n_bytes_left;
            r_sum        <= n_sum;
        end
    end

endmodule

`default_nettype wire

// ----- sv/spf_queue.sv -----
// Short command queue between front and back.
`default_nettype none

module spf_queue import spf_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_vld,
    output t_cmd      o_cmd
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_vld   = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/spf_back.sv -----
// Back end: steps through each command's bytes into the output register.
`default_nettype none

module spf_back import spf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_vld,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_vld,
    input  wire logic i_rdy,
    output logic [7:0] o_byte,
    output logic      o_last
);

    logic       r_active;
    logic [2:0] r_step;
    logic       r_out_vld;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [2:0] cur_step, start_step, next_step;
    logic [7:0] cur_byte;
    logic       load, final_step;

    always_comb begin
        unique case (i_cmd.kind)
            K_PAY:   start_step = ST_DATA;
            default: start_step = ST_SYNC0;
        endcase
    end

    assign cur_step   = r_active ? r_step : start_step;
    assign final_step = (cur_step == ST_CKS) || (cur_step == ST_DATA && !i_cmd.has_cks);
    assign next_step  = (i_cmd.kind == K_SHORT && cur_step == ST_INST) ? ST_CKS
                                                                       : cur_step + 3'd1;
    assign load       = i_cmd_vld && (!r_out_vld || i_rdy);
    assign o_cmd_pop  = load && final_step;

    always_comb begin
        unique case (cur_step)
            ST_SYNC0: cur_byte = SYNC_BYTE;
            ST_SYNC1: cur_byte = SYNC_BYTE;
            ST_ID:    cur_byte = i_cmd.id;
            ST_LEN:   cur_byte = i_cmd.len;
            ST_INST:  cur_byte = i_cmd.inst;
            ST_ADDR:  cur_byte = i_cmd.addr;
            ST_DATA:  cur_byte = i_cmd.data;
            default:  cur_byte = i_cmd.cks;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_step    <= ST_SYNC0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_active  <= !final_step;
                r_step    <= next_step;
                r_out_vld <= 1'b1;
            end else if (i_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= cur_byte;
            r_out_last <= (cur_step == ST_CKS);
        end
    end

    assign o_vld  = r_out_vld;
    assign o_byte = r_out_byte;
    assign o_last = r_out_last;

endmodule

`default_nettype wire

// ----- sv/servo_packet_framer.sv -----
// Top level of the servo instruction packet framer.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: id, instruction, addr, length, data byte
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: packet byte; tlast: checksum byte
//
// An item is taken every cycle while the command queue has room.
// The output runs one byte per cycle while m_axis_tready is high and the queue is not empty:
// 6 to 8 bytes for a packet's first item, 1 or 2 after; the back end byte sequencer sets
// the sustained rate. Synchronous active-low reset clears both ends and empties the queue.
// A stalled output holds its byte; the front keeps taking items until the queue fills.
`default_nettype none

module servo_packet_framer import spf_pkg::*; #(
    parameter int MAX_PAYLOAD = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [7:0] servo_id, [15:8] instruction, [23:16] mem_addr,
    // [30:24] payload_len, [38:31] data_byte, [39] zero
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [7:0] tx_byte
    output logic [7:0]                 m_axis_tdata,
    output logic                       m_axis_tlast
);

    logic cmd_vld_f, cmd_rdy_f, q_full, q_vld, q_pop;
    t_cmd cmd_f, cmd_q;

    assign cmd_rdy_f = !q_full;

    spf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (s_axis_tvalid),
        .o_rdy     (s_axis_tready),
        .i_data    (s_axis_tdata),
        .o_cmd_vld (cmd_vld_f),
        .o_cmd     (cmd_f),
        .i_cmd_rdy (cmd_rdy_f)
    );

    spf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_vld_f),
        .i_cmd   (cmd_f),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_cmd   (cmd_q)
    );

    spf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (q_vld),
        .i_cmd     (cmd_q),
        .o_cmd_pop (q_pop),
        .o_vld     (m_axis_tvalid),
        .i_rdy     (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- sv/spf_checker.sv -----
// Port-level checker for the servo packet framer, bound to the top level.
`default_nettype none

module spf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);

    logic [2:0] r_pos;
    logic       out_hs;

    assign out_hs = m_axis_tvalid && m_axis_tready;

    // byte position within the current packet, saturating
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
        end else if (out_hs) begin
            if (m_axis_tlast) begin
                r_pos <= 3'd0;
            end else if (r_pos != 3'd7) begin
                r_pos <= r_pos + 3'd1;
            end
        end
    end

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled request changed");

    a_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_hs && (r_pos == 3'd0 || r_pos == 3'd1) |-> m_axis_tdata == 8'hFF && !m_axis_tlast)
        else $error("packet does not open with sync bytes");

    a_short_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_hs && m_axis_tlast |-> r_pos >= 3'd5)
        else $error("checksum before end of header");

endmodule

bind servo_packet_framer spf_checker u_spf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- tb/sv/servo_packet_framer_tb.sv -----
// Self-checking testbench for the servo instruction packet framer.
`timescale 1ns / 100ps

module servo_packet_framer_tb;
    import spf_pkg::*;

    localparam int MAX_PAYLOAD = 64;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } t_tx_byte;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [7:0] servo_id, [15:8] instruction, [23:16] mem_addr,
    // [30:24] payload_len, [38:31] data_byte, [39] zero
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_tready = 1'b0;
    // [7:0] tx_byte
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;

    // predictor state
    logic [6:0]            bytes_left = '0;
    logic [7:0]            sum_acc = '0;
    t_tx_byte              pending_tx[$];
    t_tx_byte              tx_head;

    int                    mismatches = 0;
    int                    burst_left = 0;
    int                    random_items = 0;

    servo_packet_framer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("servo_packet_framer_tb: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at %0t: %s got %02h want %02h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic push_tx(input logic [7:0] b, input logic last);
        pending_tx.push_back('{tx_byte: b, last_byte: last});
    endtask

    task automatic take_payload(input logic [7:0] data);
        push_tx(data, 1'b0);
        sum_acc = sum_acc + data;
        if (bytes_left != 0)
            bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0) begin
            push_tx(~sum_acc, 1'b1);
            sum_acc = '0;
        end
    endtask

    // expected packet bytes caused by one accepted request
    task automatic predict_packet_bytes(input logic [7:0] id, input logic [7:0] inst,
                                        input logic [7:0] addr, input logic [6:0] plen,
                                        input logic [7:0] data);
        logic [6:0] n;
        logic [7:0] len;
        logic [7:0] short_sum;
        if (bytes_left != 0) begin
            take_payload(data);
        end else begin
            push_tx(SYNC_BYTE, 1'b0);
            push_tx(SYNC_BYTE, 1'b0);
            push_tx(id, 1'b0);
            if (plen == 0) begin
                // short form: address neither sent nor summed
                short_sum = id + SHORT_LEN + inst;
                push_tx(SHORT_LEN, 1'b0);
                push_tx(inst, 1'b0);
                push_tx(~short_sum, 1'b1);
                sum_acc = '0;
            end else begin
                n = (plen > MAX_PAYLOAD) ? 7'(MAX_PAYLOAD) : plen;
                len = {1'b0, n} + HDR_EXTRA;
                push_tx(len, 1'b0);
                push_tx(inst, 1'b0);
                push_tx(addr, 1'b0);
                sum_acc = id + len + inst + addr;
                bytes_left = n;
                take_payload(data);
            end
        end
    endtask

    // one request on the input side, with bursty gaps afterwards
    task automatic send_item(input logic [7:0] id, input logic [7:0] inst,
                             input logic [7:0] addr, input logic [6:0] plen,
                             input logic [7:0] data);
        int gap;
        s_tdata  <= {1'b0, data, plen, addr, inst, id};
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_packet_bytes(id, inst, addr, plen, data);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // receiver: runs of full rate, random stalls, sparse ready and long holds
    int rx_mode = 0;
    int rx_phase = 0;
    int rx_hold = 0;
    always @(posedge i_clk) begin
        if (rx_phase == 0) begin
            rx_mode  <= $urandom_range(0, 3);
            rx_phase <= $urandom_range(20, 200);
        end else begin
            rx_phase <= rx_phase - 1;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (rx_hold == 0) begin
                    rx_hold  <= $urandom_range(1, 12);
                    m_tready <= 1'b1;
                end else begin
                    rx_hold  <= rx_hold - 1;
                    m_tready <= 1'b0;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            if (pending_tx.size() == 0) begin
                report_mismatch("unexpected byte", m_axis_tdata, 8'h00);
            end else begin
                tx_head = pending_tx.pop_front();
                if (m_axis_tdata !== tx_head.tx_byte)
                    report_mismatch("tx_byte", m_axis_tdata, tx_head.tx_byte);
                if (m_axis_tlast !== tx_head.last_byte)
                    report_mismatch("last_byte", {7'd0, m_axis_tlast},
                                    {7'd0, tx_head.last_byte});
            end
        end
    end

    task automatic test_short_packets();
        send_item(8'h00, 8'h00, 8'h00, 7'd0, 8'hFF);
        send_item(8'hFE, 8'hFF, 8'hFF, 7'd0, 8'h00);
        send_item(8'hFF, 8'h02, 8'hA5, 7'd0, 8'h5A);
    endtask

    task automatic test_single_byte_packets();
        send_item(8'hFE, 8'hFF, 8'hFF, 7'd1, 8'hFF);
        send_item(8'h00, 8'h00, 8'h00, 7'd1, 8'h00);
    endtask

    task automatic test_field_extremes();
        send_item(8'hFF, 8'h03, 8'h00, 7'd2, 8'h00);
        send_item(8'h00, 8'h00, 8'h00, 7'd0, 8'hFF);
        send_item(8'h01, 8'h80, 8'hFF, 7'd2, 8'h80);
        send_item(8'hAA, 8'h55, 8'hAA, 7'd1, 8'h7F);
    endtask

    // header fields of later requests in a packet must be ignored
    task automatic test_mid_packet_headers();
        send_item(8'h12, 8'h03, 8'h1E, 7'd4, 8'h34);
        send_item(8'hFE, 8'hFF, 8'hFF, 7'd0, 8'h56);
        send_item(8'h00, 8'h00, 8'h00, 7'd127, 8'h78);
        send_item(8'hFF, 8'h02, 8'h55, 7'd1, 8'h9A);
    endtask

    task automatic test_oversized_length();
        send_item(8'($urandom), 8'($urandom), 8'($urandom), 7'd127, 8'($urandom));
        for (int i = 1; i < MAX_PAYLOAD; i++)
            send_item(8'($urandom), 8'($urandom), 8'($urandom), 7'($urandom),
                      8'($urandom));
    endtask

    task automatic test_random_packets();
        int pick;
        int count;
        logic [6:0] plen;
        logic [7:0] id;
        while (random_items < 275) begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                plen = 7'd0;
            else if (pick < 85)
                plen = 7'($urandom_range(1, 8));
            else if (pick < 95)
                plen = 7'($urandom_range(9, MAX_PAYLOAD));
            else
                plen = 7'($urandom_range(MAX_PAYLOAD + 1, 127));
            pick = $urandom_range(0, 19);
            id = (pick == 0) ? 8'hFF : (pick == 1) ? 8'hFE : 8'($urandom);
            count = (plen == 0) ? 1 : (plen > MAX_PAYLOAD) ? MAX_PAYLOAD : plen;
            send_item(id, 8'($urandom), 8'($urandom), plen, 8'($urandom));
            for (int i = 1; i < count; i++)
                send_item(8'($urandom), 8'($urandom), 8'($urandom), 7'($urandom),
                          8'($urandom));
            random_items += count;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_packets();
        test_single_byte_packets();
        test_field_extremes();
        test_mid_packet_headers();
        test_oversized_length();
        test_random_packets();
        s_tvalid <= 1'b0;
        while (pending_tx.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("servo_packet_framer_tb: PASS");
        else
            $display("servo_packet_framer_tb: FAIL");
        $finish;
    end

endmodule
